/* sv/salloc_pkg.sv */
// Shared types and codes for the slot allocator with value table.
package salloc_pkg;

    // Request kinds.
    typedef logic [1:0] t_kind;
    localparam t_kind REQ_ALLOC = 2'd0;
    localparam t_kind REQ_FREE  = 2'd1;
    localparam t_kind REQ_SET   = 2'd2;
    localparam t_kind REQ_GET   = 2'd3;

    // Result status codes.
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_BAD_INDEX = 2'd1;
    localparam t_status ST_FULL      = 2'd2;

    // The free-slot search looks at one group of this many used bits per cycle.
    localparam int CHUNK_W = 32;
    localparam int ENC_W   = $clog2(CHUNK_W);

    // Input request payload.
    typedef struct packed {
        t_kind       req_type;
        logic [7:0]  slot_index;
        logic [63:0] slot_value;
    } t_req;

    // Result payload.
    typedef struct packed {
        t_status     status;
        logic [5:0]  granted_index;
        logic [63:0] read_value;
    } t_rsp;

    // Selects which result the output register takes.
    typedef enum logic [2:0] {
        RSP_OK    = 3'd0,
        RSP_BAD   = 3'd1,
        RSP_FULL  = 3'd2,
        RSP_GRANT = 3'd3,
        RSP_READ  = 3'd4
    } t_rsp_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     wr_free;
        logic     wr_set;
        logic     rd_issue;
        logic     scan_start;
        logic     scan_next;
        logic     grant;
        logic     load_out;
        t_rsp_sel rsp_sel;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind req_kind;
        logic  idx_bad;
        logic  hit;
        logic  last;
        logic  out_free;
    } t_sts;

endpackage

/* sv/salloc_ctrl.sv */
// Controller state machine that sequences allocate scans, reads and updates.
module salloc_ctrl
    import salloc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    // A request is taken only in idle and when the output register can take a result.
    assign w_accept   = i_in_valid && (r_state == S_IDLE) && i_sts.out_free;
    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rsp_sel = RSP_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    priority if (i_sts.req_kind == REQ_ALLOC) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else if (i_sts.idx_bad) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.rsp_sel  = RSP_BAD;
                    end else if (i_sts.req_kind == REQ_FREE) begin
                        o_cmd.wr_free  = 1'b1;
                        o_cmd.load_out = 1'b1;
                    end else if (i_sts.req_kind == REQ_SET) begin
                        o_cmd.wr_set   = 1'b1;
                        o_cmd.load_out = 1'b1;
                    end else begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = S_READ;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_sts.hit) begin
                    if (i_sts.out_free) begin
                        o_cmd.grant    = 1'b1;
                        o_cmd.load_out = 1'b1;
                        o_cmd.rsp_sel  = RSP_GRANT;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.last) begin
                    if (i_sts.out_free) begin
                        o_cmd.load_out = 1'b1;
                        o_cmd.rsp_sel  = RSP_FULL;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_READ: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.rsp_sel  = RSP_READ;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* sv/salloc_dp.sv */
// Datapath: used bits, free-slot search, value memory and the output register.
module salloc_dp
    import salloc_pkg::*;
#(
    parameter int SLOT_COUNT  = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    localparam int SLOT_IDX_W  = $clog2(SLOT_COUNT);
    localparam int NUM_CHUNKS  = (SLOT_COUNT + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W       = NUM_CHUNKS * CHUNK_W;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int FOUND_W     = CHUNK_IDX_W + ENC_W;

    logic [SLOT_COUNT-1:0]  r_used;
    logic [SLOT_COUNT-1:0]  r_vld;
    logic [VALUE_WIDTH-1:0] r_mem [SLOT_COUNT];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   r_rd_vld;
    logic [CHUNK_IDX_W-1:0] r_chunk;
    logic                   r_out_valid;
    t_rsp                   r_rsp;

    logic [PAD_W-1:0]       w_used_pad;
    logic [CHUNK_W-1:0]     w_chunk;
    logic [ENC_W-1:0]       w_enc;
    logic [FOUND_W-1:0]     w_found;
    logic [SLOT_IDX_W-1:0]  w_idx;
    logic                   w_out_free;
    t_rsp                   w_rsp;

    assign w_idx      = i_req.slot_index[SLOT_IDX_W-1:0];
    assign w_out_free = !r_out_valid || !i_out_stall;

    // Slots past the pool count read as used so the search never lands on them.
    always_comb begin
        w_used_pad                 = '1;
        w_used_pad[SLOT_COUNT-1:0] = r_used;
    end

    // Lowest free slot within the current group.
    assign w_chunk = w_used_pad[r_chunk * CHUNK_W +: CHUNK_W];
    always_comb begin
        w_enc = '0;
        for (int i = CHUNK_W - 1; i >= 0; i--) begin
            if (!w_chunk[i]) begin
                w_enc = ENC_W'(i);
            end
        end
    end
    assign w_found = {r_chunk, w_enc};

    // Status toward the controller.
    always_comb begin
        o_sts.req_kind = i_req.req_type;
        o_sts.idx_bad  = {1'b0, i_req.slot_index} >= 9'(SLOT_COUNT);
        o_sts.hit      = !(&w_chunk);
        o_sts.last     = (r_chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1));
        o_sts.out_free = w_out_free;
    end

    // Used bits, entry valid bits and the search group counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_vld   <= '0;
            r_chunk <= '0;
        end else begin
            if (i_cmd.wr_free) begin
                r_used[w_idx] <= 1'b0;
                r_vld[w_idx]  <= 1'b0;
            end
            if (i_cmd.wr_set) begin
                r_vld[w_idx] <= 1'b1;
            end
            if (i_cmd.grant) begin
                r_used[w_found[SLOT_IDX_W-1:0]] <= 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_chunk <= '0;
            end else if (i_cmd.scan_next) begin
                r_chunk <= r_chunk + 1'b1;
            end
        end
    end

    // Value memory with registered read; an entry without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_set) begin
            r_mem[w_idx] <= i_req.slot_value[VALUE_WIDTH-1:0];
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[w_idx];
            r_rd_vld  <= r_vld[w_idx];
        end
    end

    // Result formatting.
    always_comb begin
        w_rsp = '0;
        unique case (i_cmd.rsp_sel)
            RSP_OK: begin
                w_rsp.status = ST_OK;
            end
            RSP_BAD: begin
                w_rsp.status = ST_BAD_INDEX;
            end
            RSP_FULL: begin
                w_rsp.status = ST_FULL;
            end
            RSP_GRANT: begin
                w_rsp.status        = ST_OK;
                w_rsp.granted_index = w_found[5:0];
            end
            RSP_READ: begin
                w_rsp.status     = ST_OK;
                w_rsp.read_value = r_rd_vld ? 64'(r_rd_data) : 64'd0;
            end
            default: begin
                w_rsp = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

endmodule

/* sv/slot_allocator_with_value_table.sv */
// Top level of the slot allocator: controller and datapath.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_stall, i_in_req)
// and every request gives exactly one result on the output channel
// (o_out_valid, i_out_stall, o_out_rsp). A request allocates the lowest free
// slot, frees a slot, sets a slot's value or gets it back.
// Flow: free, set, and a get with an out-of-range index load their result
// into the output register in the cycle that accepts them, so one such request
// per cycle is taken while that register can take a result. An in-range get
// goes through the registered memory read and the read state, and an allocate
// walks the 32-slot groups, at most ceil(SLOT_COUNT / 32), covering one group
// per cycle; no new request is taken until either has loaded its result.
// Reset: synchronous, active low. All slots become free and all values read
// as zero at once through per-slot valid bits; no clearing pass is needed.
// Stall: a result waits in the output register while i_out_stall is high, and
// the next request is held off until that register can take a new result.
module slot_allocator_with_value_table_core
    import salloc_pkg::*;
#(
    parameter int SLOT_COUNT  = 64,
    parameter int VALUE_WIDTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer.
    salloc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Storage, search and result register.
    salloc_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

`ifndef SYNTH
    // A result is never loaded over one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled result");

    // A grant only happens when the search has found a free slot.
    a_grant_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.grant |-> w_sts.hit)
        else $error("grant without a free slot");

    // After an allocate or get is accepted, the block is busy the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall &&
         (i_in_req.req_type == REQ_ALLOC ||
          (i_in_req.req_type == REQ_GET && !w_sts.idx_bad))) |=> o_in_stall)
        else $error("request accepted while a multi-cycle request is in work");
`endif

endmodule
